@@ rtl/lfs_pkg.sv @@
// Shared types, codes and drive tables for the line follow steering block.
`timescale 1ns / 1ps
`default_nettype none
package lfs_pkg;

    typedef logic signed [2:0] err_t;
    typedef logic signed [7:0] drive_t;

    typedef enum logic [1:0] {
        MODE_HOLD   = 2'd0,
        MODE_SEARCH = 2'd1,
        MODE_TRACK  = 2'd2
    } mode_t;

    localparam logic [15:0] SAMPLE_PERIOD_RST = 16'd100;

    localparam drive_t SEARCH_POS_LEFT  = -8'sd50;
    localparam drive_t SEARCH_POS_RIGHT = 8'sd50;
    localparam drive_t SEARCH_NEG_LEFT  = 8'sd87;
    localparam drive_t SEARCH_NEG_RIGHT = -8'sd87;

    function automatic drive_t track_left(input err_t e);
        drive_t d;
        unique case (e)
            3'sd3, 3'sd2: d = -8'sd40;
            3'sd1:        d = 8'sd10;
            default:      d = 8'sd100;
        endcase
        return d;
    endfunction

    function automatic drive_t track_right(input err_t e);
        drive_t d;
        unique case (e)
            3'sd3, 3'sd2: d = 8'sd80;
            -3'sd1:       d = -8'sd20;
            -3'sd2:       d = -8'sd35;
            -3'sd3:       d = -8'sd45;
            default:      d = 8'sd100;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

@@ rtl/lfs_cell.sv @@
// One stage of the error window: holds one error and passes it on when the window shifts.
`timescale 1ns / 1ps
`default_nettype none
module lfs_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          shift_en,
    input  wire lfs_pkg::err_t d,
    output lfs_pkg::err_t      q
);
    import lfs_pkg::*;

    err_t val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= '0;
        end
        else if (shift_en)
        begin
            val_reg <= d;
        end
    end

    assign q = val_reg;

endmodule
`default_nettype wire

@@ rtl/line_follow_steering.sv @@
// Top level: line error, drift window of cells, drive selection and output skid stage.
// The window shift and sum update are registered with the accepted transaction, as is its result.
// Throughput: one transaction per cycle while the skid entry is empty (s_tready high).
// A two-entry output stage (register plus skid) keeps input ready off the output handshake.
// Reset (rst_n, asynchronous, active low) clears the window, the sum, the last sample
// time and the held drive, and sets the sample period to 100 ms; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module line_follow_steering #(
    parameter int WINDOW_LEN = 30
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,     // sample_period_ms
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,       // sensors[4:0], now_ms[36:5], zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata        // mode[1:0], left_drive[9:2], right_drive[17:10],
                                            // line_error[20:18], drift_sum[28:21], zero pad
);
    import lfs_pkg::*;

    localparam int SUM_RAW = $clog2(3 * WINDOW_LEN + 1) + 1;
    localparam int SUM_W   = (SUM_RAW > 8) ? SUM_RAW : 8;
    localparam int RES_W   = 29;

    typedef logic signed [SUM_W-1:0] sum_t;

    localparam sum_t SUM_MAX = sum_t'(3 * WINDOW_LEN);
    localparam sum_t SAT_HI  = sum_t'(127);
    localparam sum_t SAT_LO  = sum_t'(-128);

    logic [15:0] period_reg;
    logic [31:0] last_ms_reg, last_ms_next;
    sum_t        sum_reg, sum_next;
    drive_t      held_left_reg, held_left_next;
    drive_t      held_right_reg, held_right_next;

    logic             out_valid_reg, skid_valid_reg;
    logic [RES_W-1:0] out_reg, skid_reg;

    logic        accept;
    logic [4:0]  sensors;
    logic [31:0] now_ms;
    logic        line_seen;
    logic        take_sample;
    logic [31:0] elapsed;
    logic signed [3:0] err_wide;
    err_t        line_error;
    mode_t       mode;
    drive_t      drift_sum;
    logic [RES_W-1:0] result;

    err_t chain [WINDOW_LEN+1];

    assign sensors = s_tdata[4:0];
    assign now_ms  = s_tdata[36:5];

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;

    assign line_seen = (sensors != 5'd0);
    assign err_wide  = 4'sd2 * $signed({3'b000, sensors[0]}) + $signed({3'b000, sensors[1]})
                     - $signed({3'b000, sensors[3]}) - 4'sd2 * $signed({3'b000, sensors[4]});
    assign line_error = line_seen ? err_t'(err_wide) : '0;

    assign elapsed     = now_ms - last_ms_reg;
    assign take_sample = accept && line_seen && (elapsed > {16'd0, period_reg});

    // window as a shift line: the tail cell is the entry being overwritten
    assign chain[0] = line_error;
    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_LEN; gi++)
        begin : g_cell
            lfs_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (take_sample),
                .d        (chain[gi]),
                .q        (chain[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        sum_next     = sum_reg;
        last_ms_next = last_ms_reg;
        if (take_sample)
        begin
            sum_next     = sum_reg - sum_t'(chain[WINDOW_LEN]) + sum_t'(line_error);
            last_ms_next = now_ms;
        end
    end

    always_comb
    begin
        held_left_next  = held_left_reg;
        held_right_next = held_right_reg;
        mode            = MODE_HOLD;
        priority if (line_seen)
        begin
            held_left_next  = track_left(line_error);
            held_right_next = track_right(line_error);
            mode            = MODE_TRACK;
        end
        else if (sum_reg > sum_t'(0))
        begin
            held_left_next  = SEARCH_POS_LEFT;
            held_right_next = SEARCH_POS_RIGHT;
            mode            = MODE_SEARCH;
        end
        else if (sum_reg < sum_t'(0))
        begin
            held_left_next  = SEARCH_NEG_LEFT;
            held_right_next = SEARCH_NEG_RIGHT;
            mode            = MODE_SEARCH;
        end
        else
        begin
            mode = MODE_HOLD;
        end
    end

    always_comb
    begin
        priority if (sum_next > SAT_HI)
            drift_sum = 8'sd127;
        else if (sum_next < SAT_LO)
            drift_sum = -8'sd128;
        else
            drift_sum = drive_t'(sum_next);
    end

    assign result = {drift_sum, line_error, held_right_next, held_left_next, mode};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg     <= SAMPLE_PERIOD_RST;
            last_ms_reg    <= '0;
            sum_reg        <= '0;
            held_left_reg  <= '0;
            held_right_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                period_reg <= cfg_wdata;
            end
            if (accept)
            begin
                last_ms_reg    <= last_ms_next;
                sum_reg        <= sum_next;
                held_left_reg  <= held_left_next;
                held_right_reg <= held_right_next;
            end
        end
    end

    // output register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (!out_valid_reg || m_tready)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (accept)
        begin
            if (!out_valid_reg || m_tready)
            begin
                out_reg <= result;
            end
            else
            begin
                skid_reg <= result;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(32 - RES_W){1'b0}}, out_reg};

    a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
        (sum_reg <= SUM_MAX) && (sum_reg >= -SUM_MAX))
        else $error("drift sum outside window bounds");

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_lost_line_keeps_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !line_seen) |=> (sum_reg == $past(sum_reg)))
        else $error("drift sum changed on a lost-line transaction");

    a_no_accept_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> ($stable(sum_reg) && $stable(last_ms_reg)))
        else $error("window state changed without an input transaction");

endmodule
`default_nettype wire

@@ dv/line_follow_steering_test.sv @@
// Self-checking testbench for the line follow steering block: stream stimulus and result check.
`timescale 1ns / 1ps
module line_follow_steering_test;
    import lfs_pkg::*;

    localparam int WINDOW       = 30;
    localparam int QUIET_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 3;

    typedef struct {
        mode_t                mode;
        drive_t               left;
        drive_t               right;
        err_t                 err;
        logic signed [7:0]    drift;
    } steer_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;       // sensors[4:0], now_ms[36:5], zero pad
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;       // mode[1:0], left_drive[9:2], right_drive[17:10],
                                // line_error[20:18], drift_sum[28:21], zero pad

    // steering model state
    logic [15:0] period_ms;
    int          err_ring [WINDOW];
    int          ring_pos;
    int          drift_total;
    logic [31:0] last_window_ms;
    drive_t      held_left;
    drive_t      held_right;
    int          track_left_tbl [7]  = '{100, 100, 100, 100, 10, -40, -40};
    int          track_right_tbl [7] = '{-45, -35, -20, 100, 100, 80, 80};

    steer_result_t pending_steer [$];
    logic [31:0]   last_sent_ms;
    int            send_idle_pct;
    int            recv_idle_pct;
    int            mismatches;
    int            quiet_cycles;

    line_follow_steering DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic steer_result_t predict_steering(input logic [4:0] sensors,
                                                       input logic [31:0] now_ms);
        steer_result_t r;
        int            e;
        logic [31:0]   elapsed;
        e = 0;
        if (sensors != 5'd0)
        begin
            e = 2 * int'(sensors[0]) + int'(sensors[1]) - int'(sensors[3])
                - 2 * int'(sensors[4]);
            elapsed = now_ms - last_window_ms;
            if (elapsed > {16'd0, period_ms})
            begin
                last_window_ms = now_ms;
                drift_total = drift_total - err_ring[ring_pos] + e;
                err_ring[ring_pos] = e;
                ring_pos = (ring_pos == WINDOW - 1) ? 0 : ring_pos + 1;
            end
            held_left  = drive_t'(track_left_tbl[e + 3]);
            held_right = drive_t'(track_right_tbl[e + 3]);
            r.mode = MODE_TRACK;
        end
        else if (drift_total > 0)
        begin
            held_left  = -8'sd50;
            held_right = 8'sd50;
            r.mode = MODE_SEARCH;
        end
        else if (drift_total < 0)
        begin
            held_left  = 8'sd87;
            held_right = -8'sd87;
            r.mode = MODE_SEARCH;
        end
        else
        begin
            r.mode = MODE_HOLD;
        end
        r.left  = held_left;
        r.right = held_right;
        r.err   = err_t'(e);
        r.drift = (drift_total > 127) ? 8'sd127 :
                  (drift_total < -128) ? -8'sd128 : 8'(drift_total);
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch on %s: got %0d, expected %0d", field, got, want);
        mismatches++;
    endtask

    // Leaves s_tvalid high after the transaction; only idling or a drain lowers it.
    task automatic send_item(input logic [4:0] sensors, input logic [31:0] now_ms);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, now_ms, sensors};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_steer.push_back(predict_steering(sensors, now_ms));
        last_sent_ms = now_ms;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_steer.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_sample_period(input logic [15:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        period_ms = value;
    endtask

    // hold after reset, every error value, both search directions, period boundary
    task automatic test_track_and_search();
        send_item(5'b00000, 32'd0);
        send_item(5'b00001, 32'd50);
        send_item(5'b00000, 32'd60);
        send_item(5'b00011, 32'd101);
        send_item(5'b00000, 32'd110);
        send_item(5'b11000, 32'd201);
        send_item(5'b11000, 32'd202);
        send_item(5'b10000, 32'd303);
        send_item(5'b00000, 32'd304);
        send_item(5'b00100, 32'd305);
        send_item(5'b00010, 32'd306);
        send_item(5'b01000, 32'd307);
        send_item(5'b11111, 32'd308);
        send_item(5'b10001, 32'd309);
        send_item(5'b01110, 32'd310);
    endtask

    task automatic test_time_wrap();
        send_item(5'b00100, 32'hFFFF_FFF0);
        send_item(5'b00110, 32'h0000_0050);
        send_item(5'b01100, 32'h0000_0060);
        send_item(5'b00000, 32'hFFFF_FFFF);
    endtask

    task automatic test_period_extremes();
        set_sample_period(16'd0);
        send_item(5'b00010, 32'd1000);
        send_item(5'b00010, 32'd1000);
        send_item(5'b01000, 32'd1001);
        set_sample_period(16'hFFFF);
        send_item(5'b01000, 32'd1001 + 32'd65535);
        send_item(5'b01000, 32'd1001 + 32'd65536);
        send_item(5'b00000, 32'd1001 + 32'd65537);
    endtask

    // fill the ring past one lap each way so old entries fall out of the sum
    task automatic test_window_wrap();
        logic [31:0] t;
        set_sample_period(16'd0);
        t = 32'h8000_0000;
        repeat (WINDOW + 5)
        begin
            t = t + 32'd1;
            send_item(5'b00011, t);
        end
        send_item(5'b00000, t);
        repeat (WINDOW + 5)
        begin
            t = t + 32'd1;
            send_item(5'b11000, t);
        end
        send_item(5'b00000, t);
    endtask

    task automatic run_random(input int count, input int send_pct, input int recv_pct,
                              input logic [15:0] period);
        logic [4:0]  line_shapes [9] = '{5'b00001, 5'b00011, 5'b00010, 5'b00110, 5'b00100,
                                         5'b01100, 5'b01000, 5'b11000, 5'b10000};
        logic [4:0]  sensors;
        logic [31:0] t;
        int          lean;
        int          pick;
        set_sample_period(period);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        t    = last_sent_ms;
        lean = 4;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                lean = $urandom_range(8);
            if (i == count / 2)
                wait_drained();
            pick = $urandom_range(99);
            if (pick < 12)
                sensors = 5'b00000;
            else if (pick < 82)
            begin
                pick = lean + $urandom_range(4) - 2;
                pick = (pick < 0) ? 0 : (pick > 8) ? 8 : pick;
                sensors = line_shapes[pick];
            end
            else
                sensors = 5'($urandom);
            pick = $urandom_range(99);
            if (pick < 85)
                t = t + $urandom_range(2 * int'(period) + 2);
            else if (pick < 95)
                t = t + $urandom_range(3);
            else
                t = $urandom;
            send_item(sensors, t);
        end
    endtask

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        steer_result_t want;
        steer_result_t got;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.mode  = mode_t'(m_tdata[1:0]);
                got.left  = m_tdata[9:2];
                got.right = m_tdata[17:10];
                got.err   = m_tdata[20:18];
                got.drift = m_tdata[28:21];
                if (pending_steer.size() == 0)
                begin
                    report_mismatch("outstanding results", 1, 0);
                end
                else
                begin
                    want = pending_steer.pop_front();
                    if (got.mode !== want.mode)
                        report_mismatch("mode", got.mode, want.mode);
                    if (got.left !== want.left)
                        report_mismatch("left_drive", got.left, want.left);
                    if (got.right !== want.right)
                        report_mismatch("right_drive", got.right, want.right);
                    if (got.err !== want.err)
                        report_mismatch("line_error", got.err, want.err);
                    if (got.drift !== want.drift)
                        report_mismatch("drift_sum", got.drift, want.drift);
                end
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[line_follow_steering] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= 16'd0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 40'd0;
        period_ms      = 16'd100;
        ring_pos       = 0;
        drift_total    = 0;
        last_window_ms = 32'd0;
        held_left      = 8'sd0;
        held_right     = 8'sd0;
        last_sent_ms   = 32'd0;
        mismatches     = 0;
        quiet_cycles   = 0;
        send_idle_pct  = 33;
        recv_idle_pct  = 81;
        foreach (err_ring[i])
            err_ring[i] = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_track_and_search();
        test_time_wrap();
        test_period_extremes();
        test_window_wrap();
        run_random(235, 33, 81, 16'd100);
        run_random(235, 81, 33, 16'($urandom_range(400)));
        run_random(235, 0, 0, 16'($urandom));
        wait_drained();

        if (mismatches == 0)
            $display("[line_follow_steering] OK");
        else
            $display("[line_follow_steering] ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/lfs_pkg.sv
rtl/lfs_cell.sv
rtl/line_follow_steering.sv
dv/line_follow_steering_test.sv
